// ----- hdl/stprs_pkg.sv -----
// Shared constants and types for the segment tree range-sum block.
// Used by the node memory and the top level; depends on nothing else.
`timescale 1ns / 1ps

package stprs_pkg;

  // Tree geometry and arithmetic widths.
  localparam int LEAVES     = 1024;
  localparam int VALUE_BITS = 32;
  localparam int SUM_BITS   = 42;
  localparam int PAD_LEAVES = 1 << $clog2(LEAVES);
  // Address width of the node store (nodes 1 .. 2*PAD_LEAVES-1).
  localparam int NODE_AW    = $clog2(2 * PAD_LEAVES);
  // Walk index width: must also hold 2*PAD_LEAVES itself.
  localparam int IDX_W      = NODE_AW + 1;

  // Operation codes carried in tuser.
  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // One access to the node store: a write, or else a read.
  typedef struct packed {
    logic                we;
    logic [NODE_AW-1:0]  addr;
    logic [SUM_BITS-1:0] wdata;
  } node_req_t;

endpackage

// ----- hdl/stprs_node_ram.sv -----
// Single-port node store of the segment tree with a registered read.
// Depends on stprs_pkg for the geometry and the request struct.
`timescale 1ns / 1ps

module stprs_node_ram (
  input  logic                          clk_i,
  input  stprs_pkg::node_req_t          req_i,
  output logic [stprs_pkg::SUM_BITS-1:0] rdata_o
);
  import stprs_pkg::*;

  logic [SUM_BITS-1:0] mem [2**NODE_AW];
  logic [SUM_BITS-1:0] rdata_q;

  // One access per cycle: a write, or a read whose data shows next cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end else begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/segment_tree_point_assign_range_sum.sv -----
// Segment tree over 1024 signed leaves with point assign and half-open range sum.
// Holds the sequencer and the shared adder; depends on stprs_pkg and stprs_node_ram.
//
// After reset the block sweeps the 2048-entry node store to zero, one entry per
// cycle, and accepts no transfer until the sweep ends. Every item then runs
// alone on a single-port node memory with a registered read, and one adder is
// shared by both operations. An assign latches and writes the leaf, then does
// one read and one write per tree level up to the root; an assign to a leaf
// past the end is dropped in its accept cycle. A query walks each level it
// covers in a left and a right step, and an empty or inverted range skips the
// walk. Its sum waits in an output register, so the next item is accepted while
// the result is still pending.
`timescale 1ns / 1ps

module segment_tree_point_assign_range_sum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: leaf_index[9:0], new_value[41:10], range_lo[52:42],
  // range_hi[63:53].
  input  logic [63:0] s_axis_tdata,
  // Fields from bit 0: kind[0].
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: range_sum[41:0], zero fill [47:42].
  output logic [47:0] m_axis_tdata
);
  import stprs_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_A_LEAF  = 7'b0000100,
    ST_A_READ  = 7'b0001000,
    ST_A_WRITE = 7'b0010000,
    ST_Q_LEFT  = 7'b0100000,
    ST_Q_RIGHT = 7'b1000000
  } state_e;

  // The done step shares nothing with the walk, so it is a separate flag.
  state_e              state_q, state_d;
  logic                done_q, done_d;
  logic [NODE_AW-1:0]  clr_cnt_q, clr_cnt_d;
  logic [NODE_AW-1:0]  node_q, node_d;
  logic [SUM_BITS-1:0] cur_q, cur_d;
  logic [SUM_BITS-1:0] acc_q, acc_d;
  logic [IDX_W-1:0]    l_q, l_d;
  logic [IDX_W-1:0]    r_q, r_d;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic [SUM_BITS-1:0] out_sum_q, out_sum_d;

  node_req_t           mem_req;
  logic [SUM_BITS-1:0] mem_rdata;

  // Input field views.
  logic [9:0]          in_leaf;
  logic [31:0]         in_value;
  logic [10:0]         in_lo;
  logic [10:0]         in_hi;
  logic [IDX_W-1:0]    lo_c;
  logic [IDX_W-1:0]    hi_c;
  logic [IDX_W-1:0]    leaf_node;
  logic [SUM_BITS-1:0] value_ext;
  logic [IDX_W-1:0]    r_dec;

  // Shared adder operands.
  logic [SUM_BITS-1:0] add_a;
  logic [SUM_BITS-1:0] add_b;
  logic [SUM_BITS-1:0] add_sum;

  stprs_node_ram u_node_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign in_leaf  = s_axis_tdata[9:0];
  assign in_value = s_axis_tdata[41:10];
  assign in_lo    = s_axis_tdata[52:42];
  assign in_hi    = s_axis_tdata[63:53];

  // Clamp the query bounds to the leaf count and place the leaf in the tree.
  assign lo_c = (IDX_W'(in_lo) > IDX_W'(LEAVES)) ? IDX_W'(LEAVES) : IDX_W'(in_lo);
  assign hi_c = (IDX_W'(in_hi) > IDX_W'(LEAVES)) ? IDX_W'(LEAVES) : IDX_W'(in_hi);
  assign leaf_node = IDX_W'(PAD_LEAVES) + IDX_W'(in_leaf);
  assign value_ext = {{(SUM_BITS - VALUE_BITS){in_value[VALUE_BITS-1]}},
                      in_value[VALUE_BITS-1:0]};

  assign r_dec = r_q[0] ? (r_q - IDX_W'(1)) : r_q;

  // One adder: parent sums during an assign, the running total during a query.
  assign add_a   = (state_q == ST_A_WRITE) ? cur_q : acc_q;
  assign add_b   = ((state_q == ST_A_WRITE) || pend_q) ? mem_rdata : '0;
  assign add_sum = add_a + add_b;

  assign s_axis_tready = (state_q == ST_IDLE) && !done_q;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    clr_cnt_d   = clr_cnt_q;
    node_d      = node_q;
    cur_d       = cur_q;
    acc_d       = acc_q;
    l_d         = l_q;
    r_d         = r_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    mem_req     = '{we: 1'b0, addr: '0, wdata: '0};

    // The output register empties on its transfer.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_req = '{we: 1'b1, addr: clr_cnt_q, wdata: '0};
        clr_cnt_d = clr_cnt_q + NODE_AW'(1);
        if (clr_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (done_q) begin
          // Hand the finished sum over once the output register is free.
          if (!out_valid_q || m_axis_tready) begin
            out_sum_d   = acc_q;
            out_valid_d = 1'b1;
            done_d      = 1'b0;
          end
        end else if (s_axis_tvalid) begin
          if (s_axis_tuser == KIND_QUERY) begin
            acc_d  = '0;
            pend_d = 1'b0;
            l_d    = lo_c + IDX_W'(PAD_LEAVES);
            r_d    = hi_c + IDX_W'(PAD_LEAVES);
            if (lo_c < hi_c) begin
              state_d = ST_Q_LEFT;
            end else begin
              done_d = 1'b1;
            end
          end else if (IDX_W'(in_leaf) < IDX_W'(LEAVES)) begin
            cur_d   = value_ext;
            node_d  = leaf_node[NODE_AW-1:0];
            state_d = ST_A_LEAF;
          end
        end
      end
      ST_A_LEAF: begin
        mem_req = '{we: 1'b1, addr: node_q, wdata: cur_q};
        state_d = ST_A_READ;
      end
      ST_A_READ: begin
        if (node_q == NODE_AW'(1)) begin
          state_d = ST_IDLE;
        end else begin
          mem_req.addr = node_q ^ NODE_AW'(1);
          state_d      = ST_A_WRITE;
        end
      end
      ST_A_WRITE: begin
        mem_req = '{we: 1'b1, addr: node_q >> 1, wdata: add_sum};
        cur_d   = add_sum;
        node_d  = node_q >> 1;
        state_d = ST_A_READ;
      end
      ST_Q_LEFT: begin
        acc_d = add_sum;
        if (l_q < r_q) begin
          if (l_q[0]) begin
            mem_req.addr = l_q[NODE_AW-1:0];
            l_d          = l_q + IDX_W'(1);
            pend_d       = 1'b1;
          end else begin
            pend_d = 1'b0;
          end
          state_d = ST_Q_RIGHT;
        end else begin
          pend_d  = 1'b0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_Q_RIGHT: begin
        acc_d = add_sum;
        if (r_q[0]) begin
          mem_req.addr = r_dec[NODE_AW-1:0];
          pend_d       = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        l_d     = l_q >> 1;
        r_d     = r_dec >> 1;
        state_d = ST_Q_LEFT;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      done_q      <= 1'b0;
      clr_cnt_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      clr_cnt_q   <= clr_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk and payload registers.
  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    cur_q     <= cur_d;
    acc_q     <= acc_d;
    l_q       <= l_d;
    r_q       <= r_d;
    out_sum_q <= out_sum_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(48 - SUM_BITS){1'b0}}, out_sum_q};

  // A pending read is only ever folded in by the query walk.
  a_pend_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_Q_LEFT) || (state_q == ST_Q_RIGHT))
    else $error("pending read outside the query walk");

  // Stepping the left bound never passes the right bound.
  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_RIGHT) |-> (l_q <= r_q))
    else $error("query bounds crossed");

  // Only the clearing sweep and an assign write the node store.
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q == ST_CLEAR) || (state_q == ST_A_LEAF)
                   || (state_q == ST_A_WRITE))
    else $error("node store written outside clear or assign");

  // A new result only comes from a finished query.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(done_q))
    else $error("result raised without a finished query");

endmodule

// ----- tb/stprs_sum_checker.sv -----
// Scoreboard for the segment tree range-sum block: watches both stream channels.
// Predicts each range sum from a leaf-level shadow store; depends on stprs_pkg.
`timescale 1ns / 1ps

module stprs_sum_checker
  import stprs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // Fields from bit 0: leaf_index[9:0], new_value[41:10], range_lo[52:42],
  // range_hi[63:53].
  input  logic [63:0] s_axis_tdata,
  // Fields from bit 0: kind[0].
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: range_sum[41:0], zero fill [47:42].
  input  logic [47:0] m_axis_tdata,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  // Shadow copy of the leaves, sign extended to full width.
  longint                leaf_vals [LEAVES];
  // Range sums still owed by the block, oldest first.
  logic [SUM_BITS-1:0]   expected_sums [$];
  int                    mismatch_total;

  logic [9:0]            in_leaf;
  logic [VALUE_BITS-1:0] in_value;
  logic [10:0]           in_lo;
  logic [10:0]           in_hi;
  logic [SUM_BITS-1:0]   got_sum;
  logic [SUM_BITS-1:0]   want_sum;

  // Sum of the leaves in [lo, hi) after clamping both ends to the leaf count.
  function automatic logic [SUM_BITS-1:0] range_total(input logic [10:0] lo_raw,
                                                      input logic [10:0] hi_raw);
    int     lo;
    int     hi;
    longint acc;
    lo  = (lo_raw > LEAVES) ? LEAVES : int'(lo_raw);
    hi  = (hi_raw > LEAVES) ? LEAVES : int'(hi_raw);
    acc = 0;
    for (int i = lo; i < hi; i++) begin
      acc += leaf_vals[i];
    end
    return acc[SUM_BITS-1:0];
  endfunction

  // Results are checked before the same edge's input transfer is predicted,
  // so a result can never be matched against an item accepted alongside it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_sums.delete();
      for (int i = 0; i < LEAVES; i++) begin
        leaf_vals[i] = 0;
      end
      mismatch_total = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_sum = m_axis_tdata[SUM_BITS-1:0];
        if (expected_sums.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10) begin
            $display("%0t: unexpected range sum transfer: got %0d (0x%h)",
                     $realtime, $signed(got_sum), got_sum);
          end
        end else begin
          want_sum = expected_sums.pop_front();
          if (got_sum !== want_sum) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
              $display("%0t: range_sum mismatch: expected %0d (0x%h), got %0d (0x%h)",
                       $realtime, $signed(want_sum), want_sum, $signed(got_sum), got_sum);
            end
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        in_leaf  = s_axis_tdata[9:0];
        in_value = s_axis_tdata[41:10];
        in_lo    = s_axis_tdata[52:42];
        in_hi    = s_axis_tdata[63:53];
        if (s_axis_tuser == KIND_ASSIGN) begin
          // Writes past the last leaf leave the tree untouched.
          if (in_leaf < LEAVES) begin
            leaf_vals[in_leaf] = longint'($signed(in_value));
          end
        end else begin
          expected_sums.push_back(range_total(in_lo, in_hi));
        end
      end

      mismatch_count_o <= mismatch_total;
      pending_count_o  <= expected_sums.size();
    end
  end

endmodule

// ----- tb/segment_tree_point_assign_range_sum_tb.sv -----
// Top of the segment tree range-sum testbench: clock, reset, stimulus and verdict.
// Instantiates the block and stprs_sum_checker; depends on stprs_pkg.
`timescale 1ns / 1ps

module segment_tree_point_assign_range_sum_tb;
  import stprs_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam longint TIMEOUT_NS = 1_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  int          mismatch_count;
  int          pending_count;

  // Pacing knobs: percent of cycles the sender idles and the receiver stalls.
  int          idle_pct;
  int          stall_pct;
  // Each flip of hold_toggle starts one long receiver hold-off.
  logic        hold_toggle;
  logic        hold_seen;
  int          hold_left;
  // Base of a narrow leaf window so that queries often cover fresh writes.
  int          window_base;

  segment_tree_point_assign_range_sum DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  stprs_sum_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: random stalls, or a long hold-off counted down here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_seen     <= 1'b0;
      hold_left     <= 0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen     <= hold_toggle;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offer one item and wait for its transfer. Valid stays high into the
  // next item unless an idle gap is drawn.
  task automatic send_op(input logic kind, input logic [9:0] leaf,
                         input logic [31:0] value, input logic [10:0] lo,
                         input logic [10:0] hi);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {hi, lo, value, leaf};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // The range fields are don't-care for an assign, so they carry noise.
  task automatic assign_leaf(input logic [9:0] leaf, input logic [31:0] value);
    send_op(KIND_ASSIGN, leaf, value, 11'($urandom), 11'($urandom));
  endtask

  // Likewise the leaf and value fields are noise for a query.
  task automatic query_range(input logic [10:0] lo, input logic [10:0] hi);
    send_op(KIND_QUERY, 10'($urandom), $urandom, lo, hi);
  endtask

  // Mostly well-formed traffic, with a share of out-of-range query bounds.
  task automatic random_op();
    int          roll;
    int          lo;
    logic [9:0]  leaf;
    logic [31:0] value;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      if ($urandom_range(0, 9) < 3) begin
        leaf = 10'(window_base + $urandom_range(0, 31));
      end else begin
        leaf = 10'($urandom);
      end
      case ($urandom_range(0, 19))
        0:       value = 32'h7FFF_FFFF;
        1:       value = 32'h8000_0000;
        2:       value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      assign_leaf(leaf, value);
    end else if (roll < 90) begin
      if ($urandom_range(0, 3) == 0) begin
        lo = window_base + $urandom_range(0, 16);
        query_range(11'(lo), 11'(lo + $urandom_range(0, 24)));
      end else begin
        lo = $urandom_range(0, LEAVES);
        query_range(11'(lo), 11'($urandom_range(lo, LEAVES)));
      end
    end else begin
      query_range(11'($urandom), 11'($urandom));
    end
  endtask

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("segment_tree_point_assign_range_sum_tb: errors");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= KIND_ASSIGN;
    s_axis_tdata  <= '0;
    hold_toggle   <= 1'b0;
    stall_pct     <= 0;
    idle_pct      = 0;
    window_base   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty tree, extreme values, overwrite, clamped,
    // empty and inverted ranges.
    query_range(11'd0, 11'd1024);
    assign_leaf(10'd0, 32'h7FFF_FFFF);
    assign_leaf(10'd1023, 32'h8000_0000);
    assign_leaf(10'd512, 32'hFFFF_FFFF);
    assign_leaf(10'd1, 32'h5555_5555);
    assign_leaf(10'd1022, 32'hAAAA_AAAA);
    query_range(11'd0, 11'd1024);
    query_range(11'd0, 11'd1);
    query_range(11'd1023, 11'd1024);
    query_range(11'd1, 11'd1023);
    query_range(11'd512, 11'd513);
    query_range(11'd5, 11'd5);
    query_range(11'd900, 11'd10);
    query_range(11'd1024, 11'd1024);
    query_range(11'd2047, 11'd2047);
    query_range(11'd0, 11'd2047);
    query_range(11'd1500, 11'd2000);
    query_range(11'd2047, 11'd0);
    assign_leaf(10'd0, 32'h8000_0000);
    assign_leaf(10'd1023, 32'h7FFF_FFFF);
    query_range(11'd0, 11'd2);
    query_range(11'd1000, 11'd1025);

    // Receiver holds off while queries keep coming, so the input backs up.
    hold_toggle <= ~hold_toggle;
    repeat (20) begin
      query_range(11'($urandom_range(0, 600)), 11'($urandom_range(600, LEAVES)));
    end

    // Random part in four pacing phases.
    for (int phase = 0; phase < 4; phase++) begin
      window_base = $urandom_range(0, LEAVES - 32);
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct  = 65;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct <= 65;
        end
        default: begin
          idle_pct  = 32;
          stall_pct <= 32;
        end
      endcase
      repeat (152) random_op();
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding sums, then give the block time for stray results.
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("segment_tree_point_assign_range_sum_tb: clean");
    end else begin
      $display("segment_tree_point_assign_range_sum_tb: errors");
    end
    $finish;
  end

endmodule
